// ===== src/cycle_duplicate_finder_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef CYCLE_DUPLICATE_FINDER_DEFINES_SVH
`define CYCLE_DUPLICATE_FINDER_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define CDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cycle_duplicate_finder: check failed");

// consequent holds in the cycle after the antecedent
`define CDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cycle_duplicate_finder: check failed");

`endif

// ===== src/cdf_pkg.sv =====
`default_nettype none
package cdf_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int VALUE_W     = 10;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W       = (CNT_W > VALUE_W) ? CNT_W : VALUE_W;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } cdf_start_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [VALUE_W-1:0] duplicate;
   } cdf_status_type;

   // pointer p (1..n) names entry p-1 of the store
   function automatic logic [ADDR_W-1:0] ptr_to_addr(input logic [CNT_W-1:0] p);
      logic [CNT_W-1:0] diff;
      diff = p - CNT_W'(1);
      return ADDR_W'(diff);
   endfunction

endpackage
`default_nettype wire

// ===== src/cdf_store.sv =====
`default_nettype none
module cdf_store (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [cdf_pkg::ADDR_W-1:0]   wr_addr,
   input  wire  [cdf_pkg::VALUE_W-1:0]  wr_data,
   input  wire                          rd_en,
   input  wire  [cdf_pkg::ADDR_W-1:0]   rd_addr,
   output logic [cdf_pkg::VALUE_W-1:0]  rd_data
);

   logic [cdf_pkg::VALUE_W-1:0] mem [cdf_pkg::MAX_ENTRIES];
   logic [cdf_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         // a read of the entry written in the same cycle returns the new value
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/cdf_walk.sv =====
`default_nettype none
`include "cycle_duplicate_finder_defines.svh"
module cdf_walk (
   input  wire                          clock,
   input  wire                          reset,
   input  wire cdf_pkg::cdf_start_type  start,
   output cdf_pkg::cdf_status_type      status,
   output logic                         rd_en,
   output logic [cdf_pkg::ADDR_W-1:0]   rd_addr,
   input  wire  [cdf_pkg::VALUE_W-1:0]  rd_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RACE_A = 3'd1;  // tortoise start arrives
   localparam logic [2:0] ST_RACE_B = 3'd2;  // hare start arrives
   localparam logic [2:0] ST_RACE_C = 3'd3;  // first hare link arrives
   localparam logic [2:0] ST_RACE_D = 3'd4;  // second hare link arrives
   localparam logic [2:0] ST_RACE_E = 3'd5;  // tortoise link arrives
   localparam logic [2:0] ST_LOC_A  = 3'd6;  // hare link arrives
   localparam logic [2:0] ST_LOC_B  = 3'd7;  // tortoise link arrives

   logic [2:0]                state_ff, state_in;
   logic [cdf_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cdf_pkg::CNT_W-1:0] hare_ff, hare_in;
   logic [cdf_pkg::CNT_W-1:0] tort_ff, tort_in;
   logic [cdf_pkg::CNT_W-1:0] data_ptr;
   logic                      done;

   assign data_ptr = cdf_pkg::CNT_W'(rd_data);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hare_in  = hare_ff;
      tort_in  = tort_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start.valid) begin
               count_in = start.count;
               rd_en    = 1'b1;
               rd_addr  = cdf_pkg::ptr_to_addr(start.count);
               state_in = ST_RACE_A;
            end
         end
         ST_RACE_A: begin
            tort_in  = data_ptr;
            rd_en    = 1'b1;
            rd_addr  = cdf_pkg::ptr_to_addr(data_ptr);
            state_in = ST_RACE_B;
         end
         ST_RACE_B: begin
            hare_in = data_ptr;
            rd_en   = 1'b1;
            if (data_ptr == tort_ff) begin
               // met: hare restarts at the last entry
               hare_in  = count_ff;
               rd_addr  = cdf_pkg::ptr_to_addr(count_ff);
               state_in = ST_LOC_A;
            end else begin
               rd_addr  = cdf_pkg::ptr_to_addr(data_ptr);
               state_in = ST_RACE_C;
            end
         end
         ST_RACE_C: begin
            rd_en    = 1'b1;
            rd_addr  = cdf_pkg::ptr_to_addr(data_ptr);
            state_in = ST_RACE_D;
         end
         ST_RACE_D: begin
            hare_in  = data_ptr;
            rd_en    = 1'b1;
            rd_addr  = cdf_pkg::ptr_to_addr(tort_ff);
            state_in = ST_RACE_E;
         end
         ST_RACE_E: begin
            tort_in = data_ptr;
            rd_en   = 1'b1;
            if (data_ptr == hare_ff) begin
               hare_in  = count_ff;
               rd_addr  = cdf_pkg::ptr_to_addr(count_ff);
               state_in = ST_LOC_A;
            end else begin
               rd_addr  = cdf_pkg::ptr_to_addr(hare_ff);
               state_in = ST_RACE_C;
            end
         end
         ST_LOC_A: begin
            hare_in  = data_ptr;
            rd_en    = 1'b1;
            rd_addr  = cdf_pkg::ptr_to_addr(tort_ff);
            state_in = ST_LOC_B;
         end
         ST_LOC_B: begin
            tort_in = data_ptr;
            if (data_ptr == hare_ff) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cdf_pkg::ptr_to_addr(hare_ff);
               state_in = ST_LOC_A;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      hare_ff  <= hare_in;
      tort_ff  <= tort_in;
   end

   assign status.busy      = (state_ff != ST_IDLE);
   assign status.done      = done;
   assign status.duplicate = cdf_pkg::VALUE_W'(hare_ff);

   `CDF_ASSERT_SAME(a_start_idle, clock, reset, start.valid, state_ff == ST_IDLE)
   `CDF_ASSERT_NEXT(a_done_idle, clock, reset, done, state_ff == ST_IDLE)
   `CDF_ASSERT_SAME(a_read_busy, clock, reset, rd_en, state_ff != ST_IDLE || start.valid)

endmodule
`default_nettype wire

// ===== src/cycle_duplicate_finder.sv =====
// list values load at one beat per cycle while req_ready is high (walker idle, and for a marked beat the result
// slot free); a result follows the marked beat. Bad lists (zero or too large value, short or overfull list) give
// their error result in the next cycle. Valid lists give their result after r race steps and m locate steps,
// all bounded by the single read port of the value store
// reset (synchronous, active high) empties the list and idles the walker;
// store contents are left as they are and only entries of the current list are read
`default_nettype none
`include "cycle_duplicate_finder_defines.svh"
module cycle_duplicate_finder (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [cdf_pkg::VALUE_W-1:0]  req_value,
   input  wire                          req_last_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [cdf_pkg::VALUE_W-1:0]  rsp_duplicate,
   output logic                         rsp_error
);

   logic [cdf_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        bad_ff, bad_in;
   logic                        zero_ff, zero_in;
   logic [cdf_pkg::VALUE_W-1:0] max_ff, max_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cdf_pkg::VALUE_W-1:0] rsp_dup_ff, rsp_dup_in;
   logic                        rsp_err_ff, rsp_err_in;

   logic                        accept;
   logic                        full;
   logic                        store_en;
   logic [cdf_pkg::CNT_W-1:0]   count_next;
   logic                        list_err;
   cdf_pkg::cdf_start_type      start;
   cdf_pkg::cdf_status_type     walk_stat;
   logic                        rd_en;
   logic [cdf_pkg::ADDR_W-1:0]  rd_addr;
   logic [cdf_pkg::VALUE_W-1:0] rd_data;

   // a marked beat needs the result slot free by the end of this cycle
   assign req_ready = !walk_stat.busy && (!rsp_valid_ff || rsp_ready || !req_last_value);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == cdf_pkg::CNT_W'(cdf_pkg::MAX_ENTRIES));
   assign store_en  = accept && !full;

   always_comb begin
      count_next = count_ff + cdf_pkg::CNT_W'(store_en);
      bad_in     = bad_ff || (accept && full);
      zero_in    = zero_ff || (store_en && (req_value == '0));
      max_in     = (store_en && (req_value > max_ff)) ? req_value : max_ff;
      list_err   = bad_in || zero_in || (count_next < cdf_pkg::CNT_W'(2))
                   || (cdf_pkg::CMP_W'(max_in) >= cdf_pkg::CMP_W'(count_next));
      count_in   = count_next;

      start.valid = 1'b0;
      start.count = count_next;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dup_in   = rsp_dup_ff;
      rsp_err_in   = rsp_err_ff;

      if (accept && req_last_value) begin
         if (list_err) begin
            rsp_valid_in = 1'b1;
            rsp_dup_in   = '0;
            rsp_err_in   = 1'b1;
         end else begin
            start.valid = 1'b1;
         end
         count_in = '0;
         bad_in   = 1'b0;
         zero_in  = 1'b0;
         max_in   = '0;
      end

      if (walk_stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_dup_in   = walk_stat.duplicate;
         rsp_err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         zero_ff      <= zero_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dup_ff <= rsp_dup_in;
      rsp_err_ff <= rsp_err_in;
   end

   cdf_store u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (cdf_pkg::ADDR_W'(count_ff)),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdf_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .status  (walk_stat),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duplicate = rsp_dup_ff;
   assign rsp_error     = rsp_err_ff;

   `CDF_ASSERT_SAME(a_done_slot_free, clock, reset, walk_stat.done, !rsp_valid_ff)
   `CDF_ASSERT_SAME(a_no_load_in_walk, clock, reset, accept, !walk_stat.busy)
   `CDF_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= cdf_pkg::CNT_W'(cdf_pkg::MAX_ENTRIES))

endmodule
`default_nettype wire
